// ===== src/nscc_pkg.sv =====
// Shared types and character constants for the NMEA checksum checker.
package nscc_pkg;

  localparam logic [7:0] CharBang   = 8'h21;  // '!'
  localparam logic [7:0] CharDollar = 8'h24;  // '$'
  localparam logic [7:0] CharStar   = 8'h2A;  // '*'
  localparam logic [7:0] CharZero   = 8'h30;  // '0'
  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'

  // Verdict for one sentence.
  typedef struct packed {
    logic       star_found;
    logic [7:0] computed_sum;
    logic       checksum_ok;
  } nscc_result_t;

  // Result hand-off from the parser to the output stage.
  typedef struct packed {
    logic         valid;
    nscc_result_t result;
  } nscc_res_if_t;

endpackage

// ===== src/nscc_parse.sv =====
// Sentence parser: per-byte state update and end-of-sentence verdict.
module nscc_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            sentence_byte_i,
  input  logic                  end_of_sentence_i,
  output nscc_pkg::nscc_res_if_t res_o
);

  localparam logic [1:0] PhWait      = 2'd0;
  localparam logic [1:0] PhBody      = 2'd1;
  localparam logic [1:0] PhTail      = 2'd2;
  localparam logic [1:0] PhStarFirst = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] body_xor_q, body_xor_d;
  logic       high_q, high_d;
  logic [1:0] tail_cnt_q, tail_cnt_d;
  logic       pend_q, pend_d;
  logic       tail_bad_q, tail_bad_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       is_ws;
  logic [7:0] body_val;

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_upper = nscc_pkg::CharZero + {4'd0, nib};
    end else begin
      hex_upper = nscc_pkg::CharUpperA + {4'd0, nib} - 8'd10;
    end
  endfunction

  assign is_ws = (sentence_byte_i == 8'h20) ||
                 ((sentence_byte_i >= 8'h09) && (sentence_byte_i <= 8'h0D));

  always_comb begin
    case (sentence_byte_i)
      nscc_pkg::CharBang:   body_val = 8'h00;
      nscc_pkg::CharDollar: body_val = 8'h01;
      default:              body_val = sentence_byte_i;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    body_xor_d = body_xor_q;
    high_d     = high_q;
    tail_cnt_d = tail_cnt_q;
    pend_d     = pend_q;
    tail_bad_d = tail_bad_q;
    first_d    = first_q;
    second_d   = second_q;
    unique case (phase_q)
      PhWait: begin
        if (!is_ws) begin
          phase_d = (sentence_byte_i == nscc_pkg::CharStar) ? PhStarFirst : PhBody;
        end
      end
      PhBody: begin
        if (sentence_byte_i == nscc_pkg::CharStar) begin
          phase_d = PhTail;
        end else begin
          body_xor_d = body_xor_q ^ body_val;
          high_d     = high_q | sentence_byte_i[7];
        end
      end
      PhTail: begin
        if (is_ws) begin
          pend_d = 1'b1;
        end else begin
          tail_bad_d = tail_bad_q | pend_q;
          if (tail_cnt_q == 2'd0) first_d = sentence_byte_i;
          if (tail_cnt_q == 2'd1) second_d = sentence_byte_i;
          if (tail_cnt_q != 2'd3) tail_cnt_d = tail_cnt_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Verdict from the state as it stands after this byte.
  always_comb begin
    res_o.valid                = accept_i & end_of_sentence_i;
    res_o.result.checksum_ok   = 1'b0;
    res_o.result.computed_sum  = 8'h00;
    res_o.result.star_found    = 1'b0;
    unique case (phase_d)
      PhBody: res_o.result.computed_sum = body_xor_d;
      PhTail: begin
        res_o.result.computed_sum = body_xor_d;
        res_o.result.star_found   = 1'b1;
        res_o.result.checksum_ok  = !high_d && !tail_bad_d && (tail_cnt_d == 2'd2) &&
                                    (first_d == hex_upper(body_xor_d[7:4])) &&
                                    (second_d == hex_upper(body_xor_d[3:0]));
      end
      PhStarFirst: res_o.result.star_found = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhWait;
      body_xor_q <= 8'h00;
      high_q     <= 1'b0;
      tail_cnt_q <= 2'd0;
      pend_q     <= 1'b0;
      tail_bad_q <= 1'b0;
      first_q    <= 8'h00;
      second_q   <= 8'h00;
    end else if (accept_i) begin
      if (end_of_sentence_i) begin
        phase_q    <= PhWait;
        body_xor_q <= 8'h00;
        high_q     <= 1'b0;
        tail_cnt_q <= 2'd0;
        pend_q     <= 1'b0;
        tail_bad_q <= 1'b0;
        first_q    <= 8'h00;
        second_q   <= 8'h00;
      end else begin
        phase_q    <= phase_d;
        body_xor_q <= body_xor_d;
        high_q     <= high_d;
        tail_cnt_q <= tail_cnt_d;
        pend_q     <= pend_d;
        tail_bad_q <= tail_bad_d;
        first_q    <= first_d;
        second_q   <= second_d;
      end
    end
  end

endmodule

// ===== src/nscc_out_reg.sv =====
// Output register holding one verdict until the downstream side takes it.
module nscc_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nscc_pkg::nscc_res_if_t res_i,
  input  logic                   ready_i,
  output logic                   valid_o,
  output logic                   free_o,
  output nscc_pkg::nscc_result_t result_o
);

  logic                   valid_q, valid_d;
  nscc_pkg::nscc_result_t result_q;

  assign free_o = !valid_q || ready_i;
  assign valid_d = res_i.valid ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      result_q <= res_i.result;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== src/nmea_sentence_checksum_check_top.sv =====
// Top level of the NMEA sentence checksum checker.
//
//   channel | direction | tdata (low bit up)                         | tlast
//   --------+-----------+--------------------------------------------+----------------
//   s_*     | in        | [7:0] sentence_byte                        | end_of_sentence
//   m_*     | out       | [0] checksum_ok, [8:1] computed_sum,       | -
//           |           | [9] star_found, [15:10] zero               |
//
// A new byte word may be taken in every cycle while no verdict waits unclaimed.
// The verdict for a sentence appears on m_* the cycle after its last byte is
// accepted, registered from the parser's combinational verdict into the output register.
// Reset returns the parser to the start of a sentence and empties the output.
// While a verdict waits unclaimed, s_tready_o drops; it rises again in the
// cycle the verdict is taken, so a stalled consumer holds back the input.
module nmea_sentence_checksum_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] sentence_byte
  input  logic        s_tlast_i,   // end_of_sentence
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o    // [0] ok, [8:1] sum, [9] star, [15:10] zero
);

  logic                   accept;
  logic                   out_free;
  nscc_pkg::nscc_res_if_t res;
  nscc_pkg::nscc_result_t result;

  // Accept a word whenever the output register can take a verdict this cycle.
  assign s_tready_o = out_free;
  assign accept     = s_tvalid_i && out_free;

  nscc_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .sentence_byte_i   (s_tdata_i),
    .end_of_sentence_i (s_tlast_i),
    .res_o             (res)
  );

  nscc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (res),
    .ready_i  (m_tready_i),
    .valid_o  (m_tvalid_o),
    .free_o   (out_free),
    .result_o (result)
  );

  // Pack the verdict, lowest field first, padded to two bytes.
  assign m_tdata_o = {6'd0, result.star_found, result.computed_sum, result.checksum_ok};

endmodule
